>>> src/slid_pkg.sv
// Shared types and constants for the step-limiting interpolator.
// Used by slid_div and step_limiting_interpolator_core; no dependencies.
package slid_pkg;

  // Input request: one target point.
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               beam_on;
    logic               frame_start;
  } slid_in_t;

  // Result request: one emitted point.
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               out_beam;
    logic               run_last;
  } slid_out_t;

  localparam int unsigned DivStepW = 6;

  // Start request into the shared divider.
  typedef struct packed {
    logic                start;
    logic [DivStepW-1:0] steps;
    logic [31:0]         dividend;
    logic [15:0]         divisor;
  } slid_div_req_t;

  // Divider result, valid in the cycle done is high.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } slid_div_rsp_t;

  // Iteration counts: step count division uses a 17-bit dividend, axis
  // division a 32-bit magnitude.
  localparam logic [DivStepW-1:0] StepsK    = 6'd17;
  localparam logic [DivStepW-1:0] StepsAxis = 6'd32;

  // Most interpolated points emitted for one target.
  localparam logic [5:0] MaxSteps = 6'd63;

  // Configuration map.
  localparam int unsigned  CfgAddrW       = 3;
  localparam logic         RegStepLimit   = 1'b0;
  localparam logic [15:0]  StepLimitReset = 16'd1152;

endpackage

>>> src/step_limiting_interpolator_core.sv
// Step-limiting interpolator for laser scan points: top level.
// Depends on slid_pkg (types, constants) and slid_div (shared divider).
//
// Usage:
//   Target points arrive on the input channel (in_valid_i / in_ready_o,
//   payload in_data_i). For each target the block emits one or more points
//   on the output channel (out_valid_o / out_ready_i, payload out_data_o).
//   The last point of every run is the target itself with run_last set.
//   step_limit is written over the APB-style port at byte address 0; the user
//   must change it only while the block is idle; the block does not enforce it.
// Timing:
//   One request is worked on at a time; in_ready_o is high only while idle.
//   With the output register free, a frame start passes from accept through
//   ST_EMIT_TGT back to idle, and an in-range target through ST_CHECK and
//   ST_EMIT_TGT. Each interpolated point takes a 17-step division for the
//   step count, then per axis one multiply and a 32-step division, all on
//   the one shared divider. At most 63 interpolated points precede a target.
// Reset:
//   step_limit returns to 1152 and no point is kept, so the first target
//   after reset passes through as a frame start.
// Stall:
//   A single output register holds the pending result; while the receiver
//   stalls, the sequencer holds in its emit state and nothing is lost.
module step_limiting_interpolator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Target points
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  slid_pkg::slid_in_t             in_data_i,
  // Emitted points
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output slid_pkg::slid_out_t            out_data_o,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slid_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import slid_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_K,
    ST_MUL_X,
    ST_NUM_X,
    ST_DIV_X,
    ST_MUL_Y,
    ST_NUM_Y,
    ST_DIV_Y,
    ST_EMIT_STEP,
    ST_EMIT_TGT
  } state_e;

  state_e             state_q, state_d;
  logic [15:0]        step_limit_q, step_limit_d;
  logic signed [15:0] tgt_x_q, tgt_x_d;
  logic signed [15:0] tgt_y_q, tgt_y_d;
  logic               beam_q, beam_d;
  logic signed [15:0] last_x_q, last_x_d;
  logic signed [15:0] last_y_q, last_y_d;
  logic               have_last_q, have_last_d;
  logic [5:0]         n_q, n_d;
  logic [15:0]        k_q, k_d;
  logic signed [16:0] dx_q, dx_d;
  logic signed [16:0] dy_q, dy_d;
  logic signed [32:0] prod_q, prod_d;
  logic               neg_q, neg_d;
  logic signed [15:0] new_x_q, new_x_d;
  logic signed [15:0] new_y_q, new_y_d;
  logic               out_valid_q, out_valid_d;
  slid_out_t          out_data_q, out_data_d;

  slid_div_req_t div_req;
  slid_div_rsp_t div_rsp;

  slid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration port: zero-wait writes and reads.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    if (paddr[2] == RegStepLimit) begin
      prdata = {16'd0, step_limit_q};
    end else begin
      prdata = '0;
    end
  end

  // Distance check datapath.
  logic signed [16:0] dx_c, dy_c;
  logic [16:0]        ax_w, ay_w;
  logic [15:0]        ax, ay, lim, m;
  logic [16:0]        m_plus;
  logic               in_range;

  assign lim      = (step_limit_q == 16'd0) ? 16'd1 : step_limit_q;
  assign dx_c     = {tgt_x_q[15], tgt_x_q} - {last_x_q[15], last_x_q};
  assign dy_c     = {tgt_y_q[15], tgt_y_q} - {last_y_q[15], last_y_q};
  assign ax_w     = dx_c[16] ? 17'(-dx_c) : 17'(dx_c);
  assign ay_w     = dy_c[16] ? 17'(-dy_c) : 17'(dy_c);
  assign ax       = ax_w[15:0];
  assign ay       = ay_w[15:0];
  assign in_range = (ax <= lim) && (ay <= lim);
  assign m        = (ax > ay) ? ax : ay;
  assign m_plus   = {1'b0, m} + {1'b0, lim} - 17'd1;

  // Shared multiply and numerator: last * k + d for the active axis.
  logic               axis_y;
  logic signed [15:0] mul_a;
  logic signed [16:0] num_d_sel;
  logic signed [33:0] num;
  logic [33:0]        num_mag;
  logic [15:0]        q16;
  logic [15:0]        axis_res;

  assign axis_y    = (state_q == ST_MUL_Y) || (state_q == ST_NUM_Y);
  assign mul_a     = axis_y ? last_y_q : last_x_q;
  assign num_d_sel = axis_y ? dy_q : dx_q;
  assign num       = {prod_q[32], prod_q} + {{17{num_d_sel[16]}}, num_d_sel};
  assign num_mag   = num[33] ? 34'(-num) : 34'(num);
  assign q16       = div_rsp.quotient[15:0];
  assign axis_res  = neg_q ? (~q16 + 16'd1) : q16;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    step_limit_d = step_limit_q;
    tgt_x_d      = tgt_x_q;
    tgt_y_d      = tgt_y_q;
    beam_d       = beam_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    have_last_d  = have_last_q;
    n_d          = n_q;
    k_d          = k_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    new_x_d      = new_x_q;
    new_y_d      = new_y_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q;
    div_req      = '0;

    if (cfg_wr && paddr[2] == RegStepLimit) begin
      step_limit_d = pwdata[15:0];
    end

    // Retire the pending result when the receiver takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tgt_x_d = in_data_i.pos_x;
          tgt_y_d = in_data_i.pos_y;
          beam_d  = in_data_i.beam_on;
          n_d     = '0;
          if (in_data_i.frame_start || !have_last_q) begin
            state_d = ST_EMIT_TGT;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        dx_d = dx_c;
        dy_d = dy_c;
        if (in_range || n_q == MaxSteps) begin
          state_d = ST_EMIT_TGT;
        end else begin
          // k = ceil(m / lim), dividend aligned to the top of the divider.
          div_req.start    = 1'b1;
          div_req.steps    = StepsK;
          div_req.dividend = {m_plus, 15'd0};
          div_req.divisor  = lim;
          state_d          = ST_DIV_K;
        end
      end
      ST_DIV_K: begin
        if (div_rsp.done) begin
          k_d     = div_rsp.quotient[15:0];
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X, ST_MUL_Y: begin
        prod_d  = 33'(mul_a) * 33'($signed({1'b0, k_q}));
        state_d = axis_y ? ST_NUM_Y : ST_NUM_X;
      end
      ST_NUM_X, ST_NUM_Y: begin
        neg_d            = num[33];
        div_req.start    = 1'b1;
        div_req.steps    = StepsAxis;
        div_req.dividend = num_mag[31:0];
        div_req.divisor  = k_q;
        state_d          = axis_y ? ST_DIV_Y : ST_DIV_X;
      end
      ST_DIV_X: begin
        if (div_rsp.done) begin
          new_x_d = axis_res;
          state_d = ST_MUL_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          new_y_d = axis_res;
          state_d = ST_EMIT_STEP;
        end
      end
      ST_EMIT_STEP: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.out_x    = new_x_q;
          out_data_d.out_y    = new_y_q;
          out_data_d.out_beam = beam_q;
          out_data_d.run_last = 1'b0;
          last_x_d            = new_x_q;
          last_y_d            = new_y_q;
          n_d                 = n_q + 6'd1;
          state_d             = ST_CHECK;
        end
      end
      ST_EMIT_TGT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.out_x    = tgt_x_q;
          out_data_d.out_y    = tgt_y_q;
          out_data_d.out_beam = beam_q;
          out_data_d.run_last = 1'b1;
          last_x_d            = tgt_x_q;
          last_y_d            = tgt_y_q;
          have_last_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_limit_q <= StepLimitReset;
      tgt_x_q      <= '0;
      tgt_y_q      <= '0;
      beam_q       <= 1'b0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      have_last_q  <= 1'b0;
      n_q          <= '0;
      k_q          <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      prod_q       <= '0;
      neg_q        <= 1'b0;
      new_x_q      <= '0;
      new_y_q      <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      step_limit_q <= step_limit_d;
      tgt_x_q      <= tgt_x_d;
      tgt_y_q      <= tgt_y_d;
      beam_q       <= beam_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      have_last_q  <= have_last_d;
      n_q          <= n_d;
      k_q          <= k_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      prod_q       <= prod_d;
      neg_q        <= neg_d;
      new_x_q      <= new_x_d;
      new_y_q      <= new_y_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Never emit a 64th interpolated point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT_STEP |-> n_q != MaxSteps)
    else $error("step count overrun");

  // The divider is never restarted while it works.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Interpolation only happens with a distance above the limit, so k >= 2.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_K && div_rsp.done |-> div_rsp.quotient[16:0] >= 17'd2)
    else $error("step count below two");

  // A finished run always leaves a kept point behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT_TGT && out_free |=> have_last_q && state_q == ST_IDLE)
    else $error("run end did not update kept point");

endmodule

>>> src/slid_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on slid_pkg for the request and response structs.
module slid_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slid_pkg::slid_div_req_t req_i,
  output slid_pkg::slid_div_rsp_t rsp_o
);
  import slid_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivStepW-1:0] cnt_q, cnt_d;
  logic [15:0]         rem_q, rem_d;
  logic [31:0]         quo_q, quo_d;
  logic [15:0]         dvs_q, dvs_d;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[15:0] : trial[15:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivStepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // Remainder stays below the divisor between steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && dvs_q != 16'd0 |=> rem_q < dvs_q)
    else $error("slid_div: remainder not reduced");

  // Done is a single-cycle pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("slid_div: done held longer than one cycle");

endmodule

>>> tb/tb.sv
// Self-checking testbench for step_limiting_interpolator_core.
// Needs slid_pkg and the core RTL; an in-bench predictor of the step
// interpolation supplies the expected points.
`timescale 1ns / 100ps

module tb;
  import slid_pkg::*;

  // Most interpolated points ahead of one target; the target follows.
  localparam int StepCap = 63;
  // Worst correct run: ~230 requests x 64 points, each with its divider work
  // and stall, plus the long output hold; allow several times that.
  localparam int unsigned CycleLimit = 6_000_000;
  // Slowest interpolated point, used for the quiet wait at the end.
  localparam int TailCycles = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  slid_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  slid_out_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Predictor copy of the block state and its one register.
  int          kept_x;
  int          kept_y;
  bit          kept_valid;
  logic [15:0] kept_limit;

  // Points the block still owes, oldest first.
  slid_out_t   points_due[$];
  slid_out_t   head_point;
  int          mismatches;

  // Traffic shaping shared by the sender, the receiver and the tests.
  bit          src_idle_on;
  bit          sink_idle_on;
  int          hold_cycles;

  step_limiting_interpolator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Give up on a hung block.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void owe_point(input int x, input int y, input logic beam,
                                    input logic last);
    slid_out_t p;
    p.out_x    = 16'(x);
    p.out_y    = 16'(y);
    p.out_beam = beam;
    p.run_last = last;
    points_due.push_back(p);
  endfunction

  // Work out every point that one accepted target request causes.
  function automatic void interpolate_target(input slid_in_t t);
    int     tx;
    int     ty;
    int     dx;
    int     dy;
    int     ax;
    int     ay;
    int     lim;
    int     n;
    longint k;
    tx  = $signed(t.pos_x);
    ty  = $signed(t.pos_y);
    // A zero limit behaves as a limit of one.
    lim = (kept_limit == 16'd0) ? 1 : int'(kept_limit);
    // Pass a frame start, or the very first point after reset, straight through.
    if (t.frame_start || !kept_valid) begin
      owe_point(tx, ty, t.beam_on, 1'b1);
      kept_x     = tx;
      kept_y     = ty;
      kept_valid = 1'b1;
      return;
    end
    n = 0;
    while (n < StepCap) begin
      dx = tx - kept_x;
      dy = ty - kept_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax <= lim && ay <= lim) break;
      k = (longint'((ax > ay) ? ax : ay) + lim - 1) / lim;
      // Exact rational step, truncated toward zero.
      kept_x = int'((longint'(kept_x) * k + dx) / k);
      kept_y = int'((longint'(kept_y) * k + dy) / k);
      owe_point(kept_x, kept_y, t.beam_on, 1'b0);
      n++;
    end
    // Close the run with the target itself.
    owe_point(tx, ty, t.beam_on, 1'b1);
    kept_x = tx;
    kept_y = ty;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: compare each accepted point with the oldest one owed.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (points_due.size() == 0) begin
        $error("unexpected point x=%0d y=%0d beam=%0b last=%0b",
               $signed(out_data_o.out_x), $signed(out_data_o.out_y),
               out_data_o.out_beam, out_data_o.run_last);
        mismatches++;
      end else begin
        head_point = points_due.pop_front();
        if (out_data_o.out_x !== head_point.out_x) begin
          $error("out_x expected %0d actual %0d",
                 $signed(head_point.out_x), $signed(out_data_o.out_x));
          mismatches++;
        end
        if (out_data_o.out_y !== head_point.out_y) begin
          $error("out_y expected %0d actual %0d",
                 $signed(head_point.out_y), $signed(out_data_o.out_y));
          mismatches++;
        end
        if (out_data_o.out_beam !== head_point.out_beam) begin
          $error("out_beam expected %0b actual %0b",
                 head_point.out_beam, out_data_o.out_beam);
          mismatches++;
        end
        if (out_data_o.run_last !== head_point.run_last) begin
          $error("run_last expected %0b actual %0b",
                 head_point.run_last, out_data_o.run_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold when a test asks.
  // ---------------------------------------------------------------------

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        // Count the hold here so the sender keeps offering meanwhile.
        out_ready_i = 1'b0;
        repeat (hold_cycles - 1) @(negedge clk_i);
        hold_cycles = 0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------

  // Offer one target request and hold it until accepted. Valid stays high
  // afterwards so back-to-back requests need no drop in between.
  task automatic send_point(input slid_in_t pt);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = pt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    interpolate_target(pt);
  endtask

  // Drop valid and pause until every owed point has come and the block idles.
  task automatic wait_until_drained;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (points_due.size() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic cfg_access(input logic write, input logic [CfgAddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_step_limit;
    logic [31:0] rd;
    cfg_access(1'b0, {RegStepLimit, 2'b00}, 32'd0, rd);
    if (rd[15:0] !== kept_limit) begin
      $error("step_limit expected %0d actual %0d", kept_limit, rd[15:0]);
      mismatches++;
    end
  endtask

  // Write step_limit (block must be idle) and read it back.
  task automatic set_step_limit(input logic [15:0] lim);
    logic [31:0] rd;
    cfg_access(1'b1, {RegStepLimit, 2'b00}, {16'd0, lim}, rd);
    kept_limit = lim;
    check_step_limit();
  endtask

  function automatic slid_in_t make_point(input int x, input int y, input bit beam,
                                          input bit fs);
    slid_in_t t;
    t.pos_x       = 16'(x);
    t.pos_y       = 16'(y);
    t.beam_on     = beam;
    t.frame_start = fs;
    return t;
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Random target: either anywhere, or within two step limits of the kept point.
  function automatic slid_in_t make_target(input bit fs, input bit near);
    slid_in_t t;
    int       reach;
    reach = 2 * ((kept_limit == 16'd0) ? 1 : int'(kept_limit));
    t.beam_on     = 1'($urandom_range(0, 1));
    t.frame_start = fs;
    if (near) begin
      t.pos_x = 16'(clamp16(kept_x + int'($urandom_range(0, 2 * reach)) - reach));
      t.pos_y = 16'(clamp16(kept_y + int'($urandom_range(0, 2 * reach)) - reach));
    end else begin
      t.pos_x = 16'($urandom);
      t.pos_y = 16'($urandom);
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset value of step_limit, and the first point with no point kept yet.
  task automatic test_reset_state;
    check_step_limit();
    send_point(make_point(100, -200, 1'b1, 1'b0));
    wait_until_drained();
  endtask

  // Coordinate extremes, exact-limit and one-past-limit moves, truncation
  // of odd negative steps, repeated points and a frame start mid-run.
  task automatic test_directed_extremes;
    send_point(make_point(-32768, -32768, 1'b0, 1'b1));
    send_point(make_point(32767, 32767, 1'b1, 1'b0));
    send_point(make_point(32767, -32768, 1'b0, 1'b0));
    send_point(make_point(32767, -32768, 1'b1, 1'b0));
    send_point(make_point(32767 - 1152, -32768 + 1152, 1'b0, 1'b0));
    send_point(make_point(32767 - 2305, -32768, 1'b1, 1'b0));
    send_point(make_point(0, 0, 1'b0, 1'b1));
    send_point(make_point(-1153, 1153, 1'b1, 1'b0));
    send_point(make_point(-32768, 32767, 1'b1, 1'b1));
    send_point(make_point(0, 0, 1'b0, 1'b0));
    send_point(make_point(-1, 1, 1'b1, 1'b0));
    wait_until_drained();
  endtask

  // Largest limit, zero limit (acts as one, hits the step cap), limit one,
  // and a limit with its top bit set.
  task automatic test_limit_extremes;
    set_step_limit(16'hFFFF);
    send_point(make_point(-32768, -32768, 1'b1, 1'b1));
    send_point(make_point(32767, 32767, 1'b0, 1'b0));
    send_point(make_point(-32768, 32767, 1'b1, 1'b0));
    wait_until_drained();
    set_step_limit(16'd0);
    send_point(make_point(0, 0, 1'b1, 1'b1));
    send_point(make_point(5, -3, 1'b0, 1'b0));
    send_point(make_point(-200, 100, 1'b1, 1'b0));
    wait_until_drained();
    set_step_limit(16'd1);
    send_point(make_point(10, 10, 1'b0, 1'b0));
    send_point(make_point(10, 11, 1'b1, 1'b0));
    wait_until_drained();
    set_step_limit(16'd40000);
    send_point(make_point(-30001, 20001, 1'b1, 1'b1));
    send_point(make_point(30000, -20000, 1'b0, 1'b0));
    wait_until_drained();
    set_step_limit(StepLimitReset);
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_stall;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    hold_cycles  = 1500;
    send_point(make_target(1'b1, 1'b0));
    for (int i = 0; i < 7; i++) send_point(make_target(1'b0, i[0]));
    wait_until_drained();
  endtask

  // Frames of random length: mostly a frame start followed by a run of
  // targets, near or far, with the odd missing or stray frame start.
  task automatic test_random_frames(input logic [15:0] lim, input int n_items,
                                    input bit all_near, input bit with_idle);
    int sent;
    int run_len;
    bit fs;
    bit near;
    set_step_limit(lim);
    src_idle_on  = with_idle;
    sink_idle_on = with_idle;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(2, 9);
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        fs   = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
        near = all_near || $urandom_range(0, 2) == 0;
        send_point(make_target(fs, near));
        sent++;
      end
    end
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    kept_x       = 0;
    kept_y       = 0;
    kept_valid   = 1'b0;
    kept_limit   = StepLimitReset;
    mismatches   = 0;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_cycles  = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_directed_extremes();
    test_limit_extremes();
    test_output_stall();

    test_random_frames(StepLimitReset, 30, 1'b0, 1'b1);
    test_random_frames(16'hFFFF, 30, 1'b0, 1'b0);
    test_random_frames(16'($urandom_range(1152, 65535)), 30, 1'b0, 1'b1);
    test_random_frames(16'($urandom_range(1152, 65535)), 30, 1'b0, 1'b1);
    // Tiny limits: keep moves short so runs stay brief.
    test_random_frames(16'($urandom_range(0, 64)), 20, 1'b1, 1'b1);
    test_random_frames(16'($urandom_range(1152, 8000)), 40, 1'b0, 1'b1);
    // Final stretch at full rate on both sides.
    test_random_frames(16'($urandom_range(1152, 65535)), 20, 1'b0, 1'b0);

    // Watch for stray points after the last owed one.
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> step_limiting_interpolator_core.f
src/slid_pkg.sv
src/slid_div.sv
src/step_limiting_interpolator_core.sv
tb/tb.sv
